@@ sv/twt_pkg.sv @@
`default_nettype none
package twt_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] CharHyphen     = 8'h2d;
  localparam logic [7:0] CharApostrophe = 8'h27;
  localparam logic [7:0] CharDot        = 8'h2e;
  localparam logic [7:0] CharPlus       = 8'h2b;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic       token_close;
    logic       run_last;
  } out_word_t;

  // results caused by one input word, in order, count of them valid
  typedef struct packed {
    out_word_t [MaxRes-1:0] res;
    logic [1:0]             count;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if ((c >= 8'h41) && (c <= 8'h5a)) begin
      return c + 8'd32;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/twt_decode.sv @@
`default_nettype none
module twt_decode
  import twt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_word_t word,
  input  wire logic     take,
  output bundle_t       bundle
);

  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    logic       close;
    logic       open_next;
  } step_t;

  logic [7:0] held_char, held_char_next;
  logic       held_valid, held_valid_next;
  logic       token_open, token_open_next;
  logic       prior_was_digit, prior_was_digit_next;

  // one byte's fate given the byte after it
  function automatic step_t decide(input logic [7:0] c, input logic has_next,
                                   input logic [7:0] nxt, input logic open_in,
                                   input logic prior_digit);
    step_t s;
    logic  keep;
    keep = 1'b0;
    if (is_alnum(c)) begin
      keep = 1'b1;
    end else if (open_in) begin
      if (c == CharHyphen || c == CharApostrophe) begin
        keep = has_next && is_alnum(nxt);
      end else if (c == CharDot) begin
        keep = prior_digit && has_next && is_digit(nxt);
      end
    end
    s.emit      = keep || open_in;
    s.ch        = keep ? to_lower(c) : 8'd0;
    s.close     = !keep;
    s.open_next = keep;
    return s;
  endfunction

  always_comb begin
    step_t      s1, s2;
    logic       t, p;
    logic [1:0] k;
    logic [7:0] b;
    b  = word.text_byte;
    t  = token_open;
    p  = prior_was_digit;
    k  = 2'd0;
    s1 = '0;
    s2 = '0;
    bundle = '0;

    if (held_valid) begin
      s1 = decide(held_char, 1'b1, b, t, p);
      if (s1.emit) begin
        bundle.res[k] = '{token_char: s1.ch, token_close: s1.close, run_last: 1'b0};
        k = k + 2'd1;
      end
      t = s1.open_next;
      p = is_digit(held_char);
    end

    if (word.end_of_text) begin
      s2 = decide(b, 1'b0, 8'd0, t, p);
      if (s2.emit) begin
        bundle.res[k] = '{token_char: s2.ch, token_close: s2.close, run_last: 1'b0};
        k = k + 2'd1;
      end
      if (s2.open_next) begin
        bundle.res[k] = '{token_char: 8'd0, token_close: 1'b1, run_last: 1'b0};
        k = k + 2'd1;
      end
      held_char_next       = '0;
      held_valid_next      = 1'b0;
      token_open_next      = 1'b0;
      prior_was_digit_next = 1'b0;
    end else begin
      held_char_next       = b;
      held_valid_next      = 1'b1;
      token_open_next      = t;
      prior_was_digit_next = p;
    end

    if (k != 2'd0) begin
      bundle.res[k - 2'd1].run_last = 1'b1;
    end
    bundle.count = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_char       <= '0;
      held_valid      <= 1'b0;
      token_open      <= 1'b0;
      prior_was_digit <= 1'b0;
    end else if (take) begin
      held_char       <= held_char_next;
      held_valid      <= held_valid_next;
      token_open      <= token_open_next;
      prior_was_digit <= prior_was_digit_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/twt_out.sv @@
`default_nettype none
module twt_out
  import twt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire bundle_t bundle,
  input  wire logic    load,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output out_word_t    out_data
);

  out_word_t [MaxRes-1:0] entries;
  logic [1:0]             rem;

  assign out_valid = (rem != 2'd0);
  assign out_data  = entries[0];
  // free for a new bundle when empty, or once the last pending word leaves this cycle
  assign free      = (rem == 2'd0) || ((rem == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= bundle.count;
    end else if (out_valid && out_ready) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= bundle.res;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/text_word_tokenizer.sv @@
`default_nettype none
// Byte-stream word tokenizer. While in_ready is high, one text byte per cycle
// enters through a one-word input register; the decode logic combinationally
// turns it into 0..3 result words (lower-cased token characters and close
// markers), and a three-entry result buffer hands them out one per cycle while
// out_ready is high. A byte is decided one word late, when the next byte
// arrives; end_of_text flushes the held byte and closes any open token.
// Sustained rate is one byte per cycle with out_ready high and at most one
// result per byte; a byte with more holds input until the output port drains it.
module text_word_tokenizer
  import twt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  in_word_t in_buf;
  logic     in_buf_valid;
  logic     out_free;
  logic     bundle_take;
  bundle_t  bundle;

  assign bundle_take = in_buf_valid && out_free;
  assign in_ready    = !in_buf_valid || bundle_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_buf_valid <= 1'b0;
    end else if (in_ready) begin
      in_buf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_buf <= in_data;
    end
  end

  twt_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .word   (in_buf),
    .take   (bundle_take),
    .bundle (bundle)
  );

  twt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .load      (bundle_take),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_buf_holds: assert property (@(posedge clk) disable iff (rst)
    in_buf_valid && !bundle_take |=> in_buf_valid && $stable(in_buf))
    else $error("held input word lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_buf_valid |-> bundle_take)
    else $error("input register overwritten before decode");

  a_busy_shows: assert property (@(posedge clk) disable iff (rst)
    !out_free |-> out_valid)
    else $error("result buffer busy with nothing offered");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_free |-> !out_data.run_last)
    else $error("run_last set before final result of a byte");
`endif

endmodule
`default_nettype wire
